### rtl/rain_gauge_hourly_binner_core_defines.svh
// Assertion macros for the rain gauge hourly binner.
// Each macro expects clk and arst_n in scope.
`ifndef RAIN_GAUGE_HOURLY_BINNER_CORE_DEFINES_SVH
`define RAIN_GAUGE_HOURLY_BINNER_CORE_DEFINES_SVH

// Same-cycle implication.
`define RGHB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rain binner check failed");

// Next-cycle implication.
`define RGHB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rain binner check failed");

`endif

### rtl/rghb_pkg.sv
package rghb_pkg;

	localparam int BINS_PER_DAY = 24;
	localparam int RAIN_WIDTH   = 32;
	localparam int IDX_W        = (BINS_PER_DAY > 1) ? $clog2(BINS_PER_DAY) : 1;

	localparam int PULSE_W = 16;
	localparam int UPP_W   = 14;
	localparam int HOUR_W  = 5;
	localparam int OUT_W   = 32;
	localparam int THR_W   = 32;
	localparam int PROD_W  = PULSE_W + UPP_W;
	localparam int SUM_W   = ((RAIN_WIDTH > PROD_W) ? RAIN_WIDTH : PROD_W) + 1;
	localparam int CMP_W   = (RAIN_WIDTH > THR_W) ? RAIN_WIDTH : THR_W;

	localparam logic [UPP_W-1:0] UPP_RESET = UPP_W'(100);

	typedef logic [RAIN_WIDTH-1:0] rain_t;
	localparam rain_t RAIN_MAX = '1;

	// configuration register indexes
	typedef enum logic {
		CFG_UM_PER_PULSE = 1'b0,
		CFG_SHUTDOWN_THR = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_SUM,
		ST_TAIL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                    wr_en;
		logic [IDX_W-1:0]        wr_addr;
		logic [BINS_PER_DAY-1:0] clr_mask;
		logic                    clr_all;
		logic                    rd_en;
		logic [IDX_W-1:0]        rd_addr;
	} bin_ctl_t;

	function automatic rain_t rain_sat_add(rain_t a, rain_t b);
		logic [RAIN_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[RAIN_WIDTH] ? RAIN_MAX : s[RAIN_WIDTH-1:0];
	endfunction

endpackage

### rtl/rghb_bin_mem.sv
module rghb_bin_mem (
	input  logic               clk,
	input  logic               arst_n,
	input  rghb_pkg::bin_ctl_t ctl,
	input  rghb_pkg::rain_t    wr_data,
	output rghb_pkg::rain_t    rd_data
);
	import rghb_pkg::*;

	rain_t                   mem [BINS_PER_DAY];
	logic [BINS_PER_DAY-1:0] vld_q;
	rain_t                   rd_data_s1;
	logic                    rd_vld_s1;
	logic [BINS_PER_DAY-1:0] wr_onehot;

	always_comb begin
		wr_onehot = '0;
		if (ctl.wr_en) begin
			wr_onehot[ctl.wr_addr] = 1'b1;
		end
	end

	// entries never written since the last clear read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (ctl.clr_all) begin
				vld_q <= '0;
			end else begin
				vld_q <= (vld_q & ~ctl.clr_mask) | wr_onehot;
			end
			if (ctl.rd_en) begin
				rd_vld_s1 <= vld_q[ctl.rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_s1 <= mem[ctl.rd_addr];
		end
	end

	assign rd_data = rd_vld_s1 ? rd_data_s1 : '0;

endmodule

### rtl/rain_gauge_hourly_binner_core.sv
// Channel | Direction | Words carried
// --------+-----------+-------------------------------------------------------------
// in      | sink      | pulse_count, clock_valid, current_hour, pivot flags
// out     | source    | shutdown, hour close, closed bin, day total, archive
// cfg     | sink      | cfg_index (0 um_per_pulse, 1 shutdown threshold), cfg_data
//
// An item that closes no hour holds the block through the idle, multiply, accumulate
// and output states; its result is registered in the output state once that register is free.
// Closing an hour adds a bin walk and a tail step before the output state: the
// day total is rebuilt by walking the bin memory through its single read port, one bin
// a cycle; on a day wrap the walked total is archived and the day total cleared.
// Reset is immediate: per-bin valid flops clear at once, no clearing pass is run.
// The output register lets the next word in while a result waits on out_ready.
// cfg is always ready and must only be written while the block is idle.
`include "rain_gauge_hourly_binner_core_defines.svh"

module rain_gauge_hourly_binner_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// input word channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rghb_pkg::PULSE_W-1:0] pulse_count,
	input  logic                         clock_valid,
	input  logic [rghb_pkg::HOUR_W-1:0]  current_hour,
	input  logic                         pivot_running,
	input  logic                         pivot_watering,
	// result word channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         shutdown_request,
	output logic                         hour_closed,
	output logic [rghb_pkg::HOUR_W-1:0]  closed_hour,
	output logic [rghb_pkg::OUT_W-1:0]   closed_hour_rain_um,
	output logic                         hourly_publish,
	output logic [rghb_pkg::OUT_W-1:0]   day_total_um,
	output logic                         day_archived,
	output logic [rghb_pkg::OUT_W-1:0]   archived_day_total_um,
	// configuration write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  rghb_pkg::cfg_idx_t           cfg_index,
	input  logic [rghb_pkg::THR_W-1:0]   cfg_data
);
	import rghb_pkg::*;

	state_t state_q, state_d;

	// configuration registers
	logic [UPP_W-1:0] upp_q;
	logic [THR_W-1:0] thr_q;

	// captured input word
	logic [PULSE_W-1:0] pulses_q;
	logic               clk_ok_q;
	logic [HOUR_W-1:0]  hour_q;
	logic               running_q;
	logic               wet_q;

	// persistent tracking state
	rain_t            acc_q;
	rain_t            day_q;
	logic [IDX_W-1:0] trk_q;
	logic             trk_vld_q;

	// per-item working registers
	logic [PROD_W-1:0] prod_q;
	logic              shut_q;
	logic              close_q;
	logic              rolled_q;
	logic [IDX_W-1:0]  last_q;
	rain_t             snap_q;
	rain_t             arch_q;
	rain_t             sum_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              rd_en_s1;

	// output register
	logic              out_vld_q;
	logic              o_shut_q;
	logic              o_close_q;
	logic [HOUR_W-1:0] o_hour_q;
	logic [OUT_W-1:0]  o_snap_q;
	logic              o_pub_q;
	logic [OUT_W-1:0]  o_day_q;
	logic              o_arch_q;
	logic [OUT_W-1:0]  o_arch_tot_q;

	// control from the sequencer
	logic accept;
	logic rd_issue;
	logic load_out;

	// accumulate stage
	logic [SUM_W-1:0] acc_sum;
	rain_t            acc_new;
	logic             shut_now;
	logic             hour_ok;
	logic [IDX_W-1:0] hour_idx;
	logic             hour_first;
	logic             hour_change;
	logic             hour_rolled;

	// bin memory
	bin_ctl_t bin_ctl;
	rain_t    bin_rd;
	rain_t    sum_fin;

	// ------------------------------------------------------------------------
	// configuration: always ready; the block does not check for idle, the user must write only while idle
	// ------------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upp_q <= UPP_RESET;
			thr_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_UM_PER_PULSE: upp_q <= cfg_data[UPP_W-1:0];
				CFG_SHUTDOWN_THR: thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// sequencer: next state
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_ACC;
			ST_ACC:  state_d = hour_change ? ST_SUM : ST_OUT;
			ST_SUM: begin
				if (cnt_q == IDX_W'(BINS_PER_DAY - 1)) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_vld_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		rd_issue = (state_q == ST_SUM);
		load_out = (state_q == ST_OUT) && (!out_vld_q || out_ready);
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------------
	// accumulate stage: saturating add of the registered product, threshold
	// check on the new total, and the hour-tracking decision
	// ------------------------------------------------------------------------
	always_comb begin
		acc_sum  = SUM_W'(acc_q) + SUM_W'(prod_q);
		acc_new  = (acc_sum > SUM_W'(RAIN_MAX)) ? RAIN_MAX : RAIN_WIDTH'(acc_sum);
		shut_now = (acc_new != '0) && (thr_q != '0)
			&& (CMP_W'(acc_new) >= CMP_W'(thr_q)) && running_q && wet_q;

		// an out-of-range hour counts as an invalid clock
		hour_ok     = clk_ok_q && (32'(hour_q) < 32'(BINS_PER_DAY));
		hour_idx    = IDX_W'(hour_q);
		hour_first  = hour_ok && !trk_vld_q;
		hour_change = hour_ok && trk_vld_q && (hour_idx != trk_q);
		hour_rolled = hour_idx < trk_q;
	end

	// ------------------------------------------------------------------------
	// bin memory control
	// ------------------------------------------------------------------------
	always_comb begin
		bin_ctl         = '0;
		bin_ctl.wr_en   = (state_q == ST_ACC) && hour_change;
		bin_ctl.wr_addr = trk_q;
		// zero the skipped bins: up to the new hour, or to the end of the day on a wrap
		for (int h = 0; h < BINS_PER_DAY; h++) begin
			bin_ctl.clr_mask[h] = bin_ctl.wr_en && (IDX_W'(h) > trk_q)
				&& (hour_rolled || (IDX_W'(h) < hour_idx));
		end
		bin_ctl.clr_all = (state_q == ST_TAIL) && rolled_q;
		bin_ctl.rd_en   = rd_issue;
		bin_ctl.rd_addr = cnt_q;
	end

	rghb_bin_mem u_bins (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (bin_ctl),
		.wr_data (acc_new),
		.rd_data (bin_rd)
	);

	assign sum_fin = rain_sat_add(sum_q, bin_rd);

	// ------------------------------------------------------------------------
	// control state
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			day_q     <= '0;
			trk_q     <= '0;
			trk_vld_q <= 1'b0;
			rd_en_s1  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_en_s1 <= rd_issue;
			if (state_q == ST_ACC) begin
				// a closing hour hands its total to the bin and restarts
				acc_q <= hour_change ? '0 : acc_new;
				if (hour_first || hour_change) begin
					trk_q     <= hour_idx;
					trk_vld_q <= 1'b1;
				end
			end
			if (state_q == ST_TAIL) begin
				day_q <= rolled_q ? '0 : sum_fin;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// payload registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			pulses_q  <= pulse_count;
			clk_ok_q  <= clock_valid;
			hour_q    <= current_hour;
			running_q <= pivot_running;
			wet_q     <= pivot_watering;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(pulses_q) * PROD_W'(upp_q);
		end
		if (state_q == ST_ACC) begin
			shut_q   <= shut_now;
			close_q  <= hour_change;
			rolled_q <= hour_change && hour_rolled;
			last_q   <= trk_q;
			snap_q   <= hour_change ? acc_new : '0;
			arch_q   <= '0;
			sum_q    <= '0;
			cnt_q    <= '0;
		end
		if (state_q == ST_SUM) begin
			cnt_q <= cnt_q + IDX_W'(1);
		end
		// the read issued in the previous cycle lands now
		if (rd_en_s1 && (state_q == ST_SUM)) begin
			sum_q <= sum_fin;
		end
		if (state_q == ST_TAIL) begin
			arch_q <= rolled_q ? sum_fin : '0;
		end
		if (load_out) begin
			o_shut_q     <= shut_q;
			o_close_q    <= close_q;
			o_hour_q     <= close_q ? HOUR_W'(last_q) : '0;
			o_snap_q     <= OUT_W'(snap_q);
			o_pub_q      <= close_q && (snap_q != '0);
			o_day_q      <= OUT_W'(day_q);
			o_arch_q     <= rolled_q;
			o_arch_tot_q <= OUT_W'(arch_q);
		end
	end

	assign out_valid             = out_vld_q;
	assign shutdown_request      = o_shut_q;
	assign hour_closed           = o_close_q;
	assign closed_hour           = o_hour_q;
	assign closed_hour_rain_um   = o_snap_q;
	assign hourly_publish        = o_pub_q;
	assign day_total_um          = o_day_q;
	assign day_archived          = o_arch_q;
	assign archived_day_total_um = o_arch_tot_q;

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	`RGHB_ASSERT_NOW(a_idle_no_read, state_q == ST_IDLE, !rd_en_s1)
	`RGHB_ASSERT_NOW(a_pub_needs_close, out_valid && hourly_publish, hour_closed)
	`RGHB_ASSERT_NOW(a_arch_clears_day, out_valid && day_archived,
		hour_closed && (day_total_um == '0))
	`RGHB_ASSERT_NEXT(a_walk_stays, state_q == ST_SUM,
		(state_q == ST_SUM) || (state_q == ST_TAIL))

endmodule
